// ===== hdl/lgr_pkg.sv =====
// Shared types, widths and defaults for the linear gradient raster unit.
package lgr_pkg;

  localparam int MAX_SIDE_DEF   = 4096;
  localparam int COORD_FRAC_DEF = 8;

  localparam int COORD_W = 24;
  localparam int DIR_W   = 25;
  localparam int LEN_W   = 51;
  localparam int VAL_W   = 32;
  localparam int SIZE_W  = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int QUO_W   = 31;   // quotient bits below the saturation limit
  localparam int FRAC_W  = 16;   // fraction bits of the result

  localparam logic [VAL_W-1:0] VAL_POS_SAT = 32'h7FFF_FFFF;
  localparam logic [VAL_W-1:0] VAL_NEG_SAT = 32'h8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIRROR_MODE  = 2'd0,
    CFG_FRAME_WIDTH  = 2'd1,
    CFG_FRAME_HEIGHT = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LEN_X,
    ST_LEN_Y,
    ST_LEN_ACC,
    ST_PREP,
    ST_NUM_X,
    ST_NUM_Y,
    ST_NUM_ACC,
    ST_ABS,
    ST_CHECK,
    ST_DIV,
    ST_FINISH
  } lgr_state_t;

endpackage

// ===== hdl/linear_gradient_raster_unit.sv =====
// Linear gradient raster unit: pixel counters, shared multiplier and serial divider.
//
// Usage: every word on the in_ channel is one pixel tick of a frame_width x
// frame_height raster scanned row by row. On the first pixel of a frame the
// start and end points are latched and the squared length of end - start is
// formed; the other pixels ignore the point fields. Each accepted word gives
// exactly one out_ word: the projection of the pixel onto the gradient axis
// as saturated signed Q15.16 (absolute value in mirror mode), out_frame_last
// on the final pixel, and out_degenerate with value 0 when the points meet.
// Configuration words on cfg_ are taken at any time (cfg_ready is high) but
// must only be sent while the unit is idle.
// Timing: one word in flight at a time. A pixel runs the products, the
// absolute value and the saturation check, then the restoring divider, one
// quotient bit a cycle through the shared subtract/compare unit; the first
// pixel of a frame forms the squared length first. A saturated projection
// skips the divider and a zero length skips the products too. The result
// waits in the output register; a stalled receiver holds the unit in its
// final step until out_ready frees the slot.
// Reset clears the counters, latched points and configuration (mirror off,
// 1 x 1 frame); no clearing pass is needed.
module linear_gradient_raster_unit #(
  parameter int MAX_SIDE   = lgr_pkg::MAX_SIDE_DEF,
  parameter int COORD_FRAC = lgr_pkg::COORD_FRAC_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [lgr_pkg::COORD_W-1:0]  in_start_px,
  input  logic signed [lgr_pkg::COORD_W-1:0]  in_start_py,
  input  logic signed [lgr_pkg::COORD_W-1:0]  in_end_px,
  input  logic signed [lgr_pkg::COORD_W-1:0]  in_end_py,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [lgr_pkg::VAL_W-1:0]    out_gradient_value,
  output logic                                out_frame_last,
  output logic                                out_degenerate,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lgr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lgr_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import lgr_pkg::*;

  localparam int CNT_W   = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 1;
  localparam int SZ_W    = ((CNT_W > SIZE_W) ? CNT_W : SIZE_W) + 1;
  localparam int PXU_W   = CNT_W + COORD_FRAC + 1;
  localparam int PX_W    = ((PXU_W > COORD_W) ? PXU_W : COORD_W) + 1;
  localparam int PROD_W  = PX_W + DIR_W;
  localparam int NUM_W   = PROD_W + 1;
  localparam int TOP_W   = NUM_W - (QUO_W - FRAC_W);
  localparam int CMP_W   = ((TOP_W > LEN_W + 1) ? TOP_W : LEN_W + 1) + 1;
  localparam int LOW_W   = QUO_W - FRAC_W;
  localparam int QCNT_W  = $clog2(QUO_W);
  localparam logic [SZ_W-1:0] SIDE_MAX = SZ_W'(MAX_SIDE);

  lgr_state_t state_r, state_nxt;

  // configuration
  logic              mirror_r;
  logic [SIZE_W-1:0] width_r, height_r;

  // raster and frame state
  logic [CNT_W-1:0]         col_r, col_nxt;
  logic [CNT_W-1:0]         row_r, row_nxt;
  logic signed [COORD_W-1:0] origin_x_r, origin_y_r;
  logic signed [DIR_W-1:0]  dir_x_r, dir_y_r;
  logic [LEN_W-1:0]         length_sq_r;

  // datapath
  logic signed [PX_W-1:0]   px_r, py_r;
  logic signed [PROD_W-1:0] prod_r, acc_r;
  logic signed [NUM_W-1:0]  num_r;
  logic [NUM_W-1:0]         mag_r;
  logic                     neg_r;
  logic                     sat_r;
  logic [LEN_W-1:0]         rem_r;
  logic [QUO_W-1:0]         bits_r, quo_r;
  logic [QCNT_W-1:0]        qcnt_r;
  logic                     last_r;

  // output register
  logic                     out_valid_r;
  logic [VAL_W-1:0]         out_value_r;
  logic                     out_last_r, out_degen_r;

  logic                     in_fire, first_px, col_end, row_end, finish_go;
  logic [SZ_W-1:0]          w_eff, h_eff;
  logic signed [PX_W-1:0]   mul_a;
  logic signed [DIR_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [NUM_W-1:0]  acc_sum;
  logic [CMP_W-1:0]         cmp_a, cmp_d;
  logic                     cmp_ge;
  logic [VAL_W-1:0]         quo_ext;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign finish_go = (state_r == ST_FINISH) && (!out_valid_r || out_ready);

  assign out_valid          = out_valid_r;
  assign out_gradient_value = out_value_r;
  assign out_frame_last     = out_last_r;
  assign out_degenerate     = out_degen_r;

  // effective frame size: zero acts as one, clamp to the largest side
  always_comb begin
    w_eff = SZ_W'(width_r);
    if (width_r == '0) begin
      w_eff = SZ_W'(1);
    end else if (SZ_W'(width_r) > SIDE_MAX) begin
      w_eff = SIDE_MAX;
    end
    h_eff = SZ_W'(height_r);
    if (height_r == '0) begin
      h_eff = SZ_W'(1);
    end else if (SZ_W'(height_r) > SIDE_MAX) begin
      h_eff = SIDE_MAX;
    end
  end

  assign first_px = (col_r == '0) && (row_r == '0);
  assign col_end  = (SZ_W'(col_r) + SZ_W'(1)) >= w_eff;
  assign row_end  = (SZ_W'(row_r) + SZ_W'(1)) >= h_eff;

  // advance the raster once the pixel's word is handed to the output
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (finish_go) begin
      if (col_end) begin
        col_nxt = '0;
        row_nxt = row_end ? '0 : row_r + CNT_W'(1);
      end else begin
        col_nxt = col_r + CNT_W'(1);
      end
    end
  end

  // shared multiplier operand selection
  always_comb begin
    unique case (state_r)
      ST_LEN_X: begin
        mul_a = PX_W'(dir_x_r);
        mul_b = dir_x_r;
      end
      ST_LEN_Y: begin
        mul_a = PX_W'(dir_y_r);
        mul_b = dir_y_r;
      end
      ST_NUM_Y: begin
        mul_a = py_r;
        mul_b = dir_y_r;
      end
      default: begin
        mul_a = px_r;
        mul_b = dir_x_r;
      end
    endcase
  end

  assign mul_p   = mul_a * mul_b;
  assign acc_sum = NUM_W'(acc_r) + NUM_W'(prod_r);

  // shared subtract/compare: saturation check, then one quotient bit a cycle
  assign cmp_a  = (state_r == ST_CHECK) ? CMP_W'(mag_r[NUM_W-1:LOW_W])
                                        : CMP_W'({rem_r, bits_r[QUO_W-1]});
  assign cmp_d  = cmp_a - CMP_W'(length_sq_r);
  assign cmp_ge = !cmp_d[CMP_W-1];

  assign quo_ext = {1'b0, quo_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = first_px ? ST_LEN_X : ST_PREP;
        end
      end
      ST_LEN_X:   state_nxt = ST_LEN_Y;
      ST_LEN_Y:   state_nxt = ST_LEN_ACC;
      ST_LEN_ACC: state_nxt = ST_PREP;
      ST_PREP:    state_nxt = (length_sq_r == '0) ? ST_FINISH : ST_NUM_X;
      ST_NUM_X:   state_nxt = ST_NUM_Y;
      ST_NUM_Y:   state_nxt = ST_NUM_ACC;
      ST_NUM_ACC: state_nxt = ST_ABS;
      ST_ABS:     state_nxt = ST_CHECK;
      ST_CHECK:   state_nxt = cmp_ge ? ST_FINISH : ST_DIV;
      ST_DIV: begin
        if (qcnt_r == '0) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration, counters and frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mirror_r    <= 1'b0;
      width_r     <= SIZE_W'(1);
      height_r    <= SIZE_W'(1);
      col_r       <= '0;
      row_r       <= '0;
      origin_x_r  <= '0;
      origin_y_r  <= '0;
      dir_x_r     <= '0;
      dir_y_r     <= '0;
      length_sq_r <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_MIRROR_MODE:  mirror_r <= cfg_data[0];
          CFG_FRAME_WIDTH:  width_r  <= cfg_data[SIZE_W-1:0];
          CFG_FRAME_HEIGHT: height_r <= cfg_data[SIZE_W-1:0];
          default: ;
        endcase
      end
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (in_fire && first_px) begin
        origin_x_r <= in_start_px;
        origin_y_r <= in_start_py;
        dir_x_r    <= DIR_W'(in_end_px) - DIR_W'(in_start_px);
        dir_y_r    <= DIR_W'(in_end_py) - DIR_W'(in_start_py);
      end
      if (state_r == ST_LEN_ACC) begin
        length_sq_r <= acc_sum[LEN_W-1:0];
      end
    end
  end

  // arithmetic datapath, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      last_r <= col_end && row_end;
    end
    if (state_r == ST_PREP) begin
      px_r <= $signed(PX_W'(col_r) << COORD_FRAC) - PX_W'(origin_x_r);
      py_r <= $signed(PX_W'(row_r) << COORD_FRAC) - PX_W'(origin_y_r);
    end
    if (state_r == ST_LEN_X || state_r == ST_LEN_Y ||
        state_r == ST_NUM_X || state_r == ST_NUM_Y) begin
      prod_r <= mul_p;
      acc_r  <= prod_r;
    end
    if (state_r == ST_NUM_ACC) begin
      num_r <= acc_sum;
    end
    if (state_r == ST_ABS) begin
      mag_r <= num_r[NUM_W-1] ? NUM_W'(-num_r) : NUM_W'(num_r);
      neg_r <= num_r[NUM_W-1] && !mirror_r;
    end
    if (state_r == ST_CHECK) begin
      // a saturated projection skips the divider
      sat_r  <= cmp_ge;
      rem_r  <= LEN_W'(mag_r[NUM_W-1:LOW_W]);
      bits_r <= {mag_r[LOW_W-1:0], {FRAC_W{1'b0}}};
      quo_r  <= '0;
      qcnt_r <= QCNT_W'(QUO_W - 1);
    end
    if (state_r == ST_DIV) begin
      rem_r  <= cmp_ge ? cmp_d[LEN_W-1:0] : cmp_a[LEN_W-1:0];
      bits_r <= {bits_r[QUO_W-2:0], 1'b0};
      quo_r  <= {quo_r[QUO_W-2:0], cmp_ge};
      qcnt_r <= qcnt_r - QCNT_W'(1);
    end
  end

  // output register: load when the slot is free, drop valid when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (finish_go) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish_go) begin
      out_last_r <= last_r;
      if (length_sq_r == '0) begin
        out_value_r <= '0;
        out_degen_r <= 1'b1;
      end else if (sat_r) begin
        out_degen_r <= 1'b0;
        out_value_r <= neg_r ? VAL_NEG_SAT : VAL_POS_SAT;
      end else begin
        out_degen_r <= 1'b0;
        out_value_r <= neg_r ? VAL_W'(-quo_ext) : quo_ext;
      end
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the linear gradient raster unit: table-driven and random pixels.
`timescale 1ns / 100ps

module testbench;
  import lgr_pkg::*;

  localparam int ITEM_TARGET = 1050;
  localparam int LONG_HOLD   = 300;
  localparam int SETTLE      = 64;
  localparam int SIDE_MAX    = MAX_SIDE_DEF;
  localparam int FRAC        = COORD_FRAC_DEF;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [VAL_W-1:0]          value_t;

  typedef struct packed {
    value_t value;
    logic   last;
    logic   degen;
  } pixel_t;

  typedef enum logic [1:0] {ROW_SETUP, ROW_PIXEL, ROW_KNOWN} row_kind_t;
  typedef enum {DRAIN_FULL, DRAIN_BUSY, DRAIN_SPARSE, DRAIN_COMB} drain_t;

  typedef struct packed {
    row_kind_t          kind;
    logic               mirror;
    logic [SIZE_W-1:0]  width;
    logic [SIZE_W-1:0]  height;
    coord_t             sx;
    coord_t             sy;
    coord_t             ex;
    coord_t             ey;
    pixel_t             known;
  } plan_row_t;

  localparam coord_t C_MIN  = 24'sh800000;
  localparam coord_t C_MAX  = 24'sh7FFFFF;
  localparam pixel_t NO_PIX = '0;

  // Known results are for 1 x 1 frames, so every pixel latches its own points.
  localparam plan_row_t PLAN [0:27] = '{
    '{ROW_KNOWN, 1'b0, 13'd0, 13'd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0,
      '{32'h0000_0000, 1'b1, 1'b1}},
    '{ROW_KNOWN, 1'b0, 13'd0, 13'd0, -24'sd256, 24'sd0, 24'sd0, 24'sd0,
      '{32'h0001_0000, 1'b1, 1'b0}},
    '{ROW_KNOWN, 1'b0, 13'd0, 13'd0, 24'sd256, 24'sd0, 24'sd512, 24'sd0,
      '{32'hFFFF_0000, 1'b1, 1'b0}},
    '{ROW_KNOWN, 1'b0, 13'd0, 13'd0, C_MIN, 24'sd0, -24'sd8388607, 24'sd0,
      '{VAL_POS_SAT, 1'b1, 1'b0}},
    '{ROW_KNOWN, 1'b0, 13'd0, 13'd0, 24'sd8388606, 24'sd0, C_MAX, 24'sd0,
      '{VAL_NEG_SAT, 1'b1, 1'b0}},
    '{ROW_KNOWN, 1'b0, 13'd0, 13'd0, C_MIN, C_MIN, C_MAX, C_MAX,
      '{32'h0000_8000, 1'b1, 1'b0}},
    '{ROW_KNOWN, 1'b0, 13'd0, 13'd0, C_MAX, C_MIN, C_MAX, C_MIN,
      '{32'h0000_0000, 1'b1, 1'b1}},
    '{ROW_SETUP, 1'b1, 13'd1, 13'd1, 24'sd0, 24'sd0, 24'sd0, 24'sd0, NO_PIX},
    '{ROW_KNOWN, 1'b0, 13'd0, 13'd0, 24'sd256, 24'sd0, 24'sd512, 24'sd0,
      '{32'h0001_0000, 1'b1, 1'b0}},
    '{ROW_KNOWN, 1'b0, 13'd0, 13'd0, 24'sd8388606, 24'sd0, C_MAX, 24'sd0,
      '{VAL_POS_SAT, 1'b1, 1'b0}},
    '{ROW_PIXEL, 1'b0, 13'd0, 13'd0, 24'sd100, -24'sd37, -24'sd3000, 24'sd777, NO_PIX},
    '{ROW_SETUP, 1'b0, 13'd3, 13'd2, 24'sd0, 24'sd0, 24'sd0, 24'sd0, NO_PIX},
    '{ROW_PIXEL, 1'b0, 13'd0, 13'd0, -24'sd100, 24'sd50, 24'sd700, -24'sd333, NO_PIX},
    '{ROW_PIXEL, 1'b0, 13'd0, 13'd0, C_MAX, C_MAX, C_MAX, C_MAX, NO_PIX},
    '{ROW_PIXEL, 1'b0, 13'd0, 13'd0, C_MIN, C_MIN, C_MIN, C_MIN, NO_PIX},
    '{ROW_PIXEL, 1'b0, 13'd0, 13'd0, 24'sh555555, 24'sh2AAAAA, 24'sh555555, 24'sh2AAAAA,
      NO_PIX},
    '{ROW_PIXEL, 1'b0, 13'd0, 13'd0, -24'sd1, -24'sd1, -24'sd1, -24'sd1, NO_PIX},
    '{ROW_PIXEL, 1'b0, 13'd0, 13'd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, NO_PIX},
    // zero width acts as one, oversize height as the maximum
    '{ROW_SETUP, 1'b0, 13'd0, 13'h1FFF, 24'sd0, 24'sd0, 24'sd0, 24'sd0, NO_PIX},
    '{ROW_PIXEL, 1'b0, 13'd0, 13'd0, 24'sd0, 24'sd0, 24'sd0, 24'sd4096, NO_PIX},
    '{ROW_PIXEL, 1'b0, 13'd0, 13'd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, NO_PIX},
    '{ROW_PIXEL, 1'b0, 13'd0, 13'd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, NO_PIX},
    '{ROW_SETUP, 1'b1, 13'd4096, 13'd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, NO_PIX},
    '{ROW_PIXEL, 1'b0, 13'd0, 13'd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, NO_PIX},
    '{ROW_PIXEL, 1'b0, 13'd0, 13'd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, NO_PIX},
    // shrink mid-frame: both counters already past the new limits
    '{ROW_SETUP, 1'b1, 13'd2, 13'd2, 24'sd0, 24'sd0, 24'sd0, 24'sd0, NO_PIX},
    '{ROW_PIXEL, 1'b0, 13'd0, 13'd0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, NO_PIX},
    '{ROW_PIXEL, 1'b0, 13'd0, 13'd0, 24'sd512, 24'sd512, 24'sd0, 24'sd0, NO_PIX}
  };

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  coord_t                in_start_px, in_start_py, in_end_px, in_end_py;
  logic                  out_valid;
  logic                  out_ready;
  logic signed [VAL_W-1:0] out_gradient_value;
  logic                  out_frame_last;
  logic                  out_degenerate;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // predictor copy of configuration and raster state
  logic                    mirror_on;
  logic [SIZE_W-1:0]       width_reg, height_reg;
  logic [11:0]             col_pos, row_pos;
  coord_t                  org_x, org_y;
  logic signed [DIR_W-1:0] axis_x, axis_y;
  logic [LEN_W-1:0]        axis_len2;

  pixel_t pending_gradients[$];

  int  fault_count   = 0;
  int  items_sent    = 0;
  int  checked_count = 0;
  int  frame_ends    = 0;
  int  flat_count    = 0;
  int  clipped_count = 0;
  int  setups_done   = 0;
  int  holds_done    = 0;
  int  burst_left    = 0;
  bit  hold_off_req  = 1'b0;

  always #6 clk = ~clk;

  linear_gradient_raster_unit u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_start_px        (in_start_px),
    .in_start_py        (in_start_py),
    .in_end_px          (in_end_px),
    .in_end_py          (in_end_py),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_gradient_value (out_gradient_value),
    .out_frame_last     (out_frame_last),
    .out_degenerate     (out_degenerate),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  function automatic int unsigned clamp_side(logic [SIZE_W-1:0] v);
    if (v == 0) return 1;
    if (v > SIDE_MAX) return SIDE_MAX;
    return 32'(v);
  endfunction

  // Q15.16 of num / den, truncated toward zero, saturated
  function automatic value_t fixed_ratio(longint num, longint unsigned den, logic mirror);
    logic            neg;
    longint unsigned mag, quo, rem, m;
    neg = (num < 0) && !mirror;
    mag = (num < 0) ? -num : num;
    quo = mag / den;
    rem = mag % den;
    if (quo >= 64'h1_0000) begin
      m = 64'h1_0000_0000;
    end else begin
      m = quo;
      repeat (FRAC_W) begin
        rem = rem << 1;
        m = m << 1;
        if (rem >= den) begin
          rem = rem - den;
          m = m | 64'd1;
        end
      end
    end
    if (neg) begin
      if (m > 64'h8000_0000) m = 64'h8000_0000;
      m = ~m + 64'd1;
      return m[31:0];
    end
    if (m > 64'h7FFF_FFFF) m = 64'h7FFF_FFFF;
    return m[31:0];
  endfunction

  // Work out the result of one pixel tick and advance the raster counters.
  function automatic pixel_t project_pixel(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
    pixel_t      r;
    int unsigned w, h;
    longint      rel_x, rel_y, num;
    logic        col_end, row_end;
    w = clamp_side(width_reg);
    h = clamp_side(height_reg);
    if (col_pos == 0 && row_pos == 0) begin
      org_x = sx;
      org_y = sy;
      axis_x = DIR_W'(longint'(ex) - longint'(sx));
      axis_y = DIR_W'(longint'(ey) - longint'(sy));
      axis_len2 = LEN_W'(longint'(axis_x) * longint'(axis_x) +
                         longint'(axis_y) * longint'(axis_y));
    end
    r = '0;
    if (axis_len2 == 0) begin
      r.degen = 1'b1;
    end else begin
      rel_x = longint'(col_pos) * (longint'(1) << FRAC) - longint'(org_x);
      rel_y = longint'(row_pos) * (longint'(1) << FRAC) - longint'(org_y);
      num = rel_x * longint'(axis_x) + rel_y * longint'(axis_y);
      r.value = fixed_ratio(num, 64'(axis_len2), mirror_on);
    end
    col_end = (col_pos + 13'd1) >= w;
    row_end = (row_pos + 13'd1) >= h;
    r.last = col_end && row_end;
    if (col_end) begin
      col_pos = '0;
      row_pos = row_end ? 12'd0 : row_pos + 12'd1;
    end else begin
      col_pos = col_pos + 12'd1;
    end
    return r;
  endfunction

  function automatic logic [SIZE_W-1:0] pick_side();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return 13'd4096;
      2:       return 13'h1FFF;
      3:       return SIZE_W'($urandom_range(9, 8191));
      default: return SIZE_W'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic coord_t corner_coord();
    case ($urandom_range(0, 3))
      0:       return C_MIN;
      1:       return C_MAX;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  function automatic void pick_points(output coord_t sx, output coord_t sy,
                                      output coord_t ex, output coord_t ey);
    case ($urandom_range(0, 19))
      0, 1: begin
        // coincident points
        sx = coord_t'($urandom);
        sy = coord_t'($urandom);
        ex = sx;
        ey = sy;
      end
      2, 3, 4: begin
        // very short axis, mostly saturating
        sx = coord_t'($urandom);
        sy = coord_t'($urandom);
        ex = sx + coord_t'(int'($urandom_range(0, 4)) - 2);
        ey = sy + coord_t'(int'($urandom_range(0, 4)) - 2);
      end
      5, 6: begin
        sx = corner_coord();
        sy = corner_coord();
        ex = corner_coord();
        ey = corner_coord();
      end
      7, 8, 9, 10, 11: begin
        sx = coord_t'($urandom);
        sy = coord_t'($urandom);
        ex = coord_t'($urandom);
        ey = coord_t'($urandom);
      end
      default: begin
        sx = coord_t'(int'($urandom_range(0, 1 << 15)) - (1 << 14));
        sy = coord_t'(int'($urandom_range(0, 1 << 15)) - (1 << 14));
        ex = coord_t'(int'($urandom_range(0, 1 << 15)) - (1 << 14));
        ey = coord_t'(int'($urandom_range(0, 1 << 15)) - (1 << 14));
      end
    endcase
  endfunction

  task automatic offer_pixel(coord_t sx, coord_t sy, coord_t ex, coord_t ey,
                             logic use_known, pixel_t known);
    pixel_t guess;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
    end
    burst_left--;
    guess = project_pixel(sx, sy, ex, ey);
    pending_gradients.push_back(use_known ? known : guess);
    in_valid    <= 1'b1;
    in_start_px <= sx;
    in_start_py <= sy;
    in_end_px   <= ex;
    in_end_py   <= ey;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Hold the input until every outstanding word has come back.
  task automatic drain_all();
    in_valid <= 1'b0;
    while (pending_gradients.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_setup(logic [CFG_DATA_W-1:0] mirror_word,
                            logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h);
    drain_all();
    write_reg(CFG_MIRROR_MODE, mirror_word);
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
    mirror_on  = mirror_word[0];
    width_reg  = w;
    height_reg = h;
    setups_done++;
  endtask

  always @(posedge clk) begin : check_out
    pixel_t due;
    if (rst_n && out_valid && out_ready) begin
      if (pending_gradients.size() == 0) begin
        $display("%0t: unexpected word value=%h last=%b degen=%b", $time,
                 out_gradient_value, out_frame_last, out_degenerate);
        fault_count++;
      end else begin
        due = pending_gradients.pop_front();
        if (out_gradient_value !== due.value) begin
          $display("%0t: gradient_value expected %h got %h", $time, due.value,
                   out_gradient_value);
          fault_count++;
        end
        if (out_frame_last !== due.last) begin
          $display("%0t: frame_last expected %b got %b", $time, due.last, out_frame_last);
          fault_count++;
        end
        if (out_degenerate !== due.degen) begin
          $display("%0t: degenerate expected %b got %b", $time, due.degen, out_degenerate);
          fault_count++;
        end
        checked_count++;
        if (due.last) frame_ends++;
        if (due.degen) flat_count++;
        if (due.value == VAL_POS_SAT || due.value == VAL_NEG_SAT) clipped_count++;
      end
    end
  end

  initial begin : drain_side
    drain_t style;
    int     span;
    int     tick;
    out_ready <= 1'b0;
    tick = 0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_off_req = 1'b0;
        holds_done++;
      end
      style = drain_t'($urandom_range(0, 3));
      span = $urandom_range(8, 80);
      repeat (span) begin
        if (hold_off_req) break;
        case (style)
          DRAIN_FULL:   out_ready <= 1'b1;
          DRAIN_BUSY:   out_ready <= ($urandom_range(0, 9) < 7);
          DRAIN_SPARSE: out_ready <= ($urandom_range(0, 9) < 3);
          default:      out_ready <= (tick % 5) > 1;
        endcase
        tick++;
        @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    #8_000_000;
    $display("Timeout with %0d words outstanding", pending_gradients.size());
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    coord_t      sx, sy, ex, ey;
    int unsigned area;
    int          n;
    int          phase;
    int          directed_items;
    in_valid    <= 1'b0;
    in_start_px <= '0;
    in_start_py <= '0;
    in_end_px   <= '0;
    in_end_py   <= '0;
    cfg_valid   <= 1'b0;
    cfg_index   <= CFG_MIRROR_MODE;
    cfg_data    <= '0;
    rst_n       <= 1'b0;
    mirror_on  = 1'b0;
    width_reg  = 13'd1;
    height_reg = 13'd1;
    col_pos    = '0;
    row_pos    = '0;
    org_x      = '0;
    org_y      = '0;
    axis_x     = '0;
    axis_y     = '0;
    axis_len2  = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < 28; i++) begin
      case (PLAN[i].kind)
        ROW_SETUP: load_setup({12'd0, PLAN[i].mirror}, PLAN[i].width, PLAN[i].height);
        default:   offer_pixel(PLAN[i].sx, PLAN[i].sy, PLAN[i].ex, PLAN[i].ey,
                               PLAN[i].kind == ROW_KNOWN, PLAN[i].known);
      endcase
    end
    directed_items = items_sent;

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      phase++;
      if (phase == 1 || $urandom_range(0, 9) < 6)
        load_setup(CFG_DATA_W'($urandom), pick_side(), pick_side());
      area = clamp_side(width_reg) * clamp_side(height_reg);
      if (phase == 8) begin
        // stall the output for a long stretch while pixels keep coming
        hold_off_req = 1'b1;
        n = 20;
      end else if (area <= 64) begin
        n = $urandom_range(1, 2 * area + 2);
      end else begin
        n = $urandom_range(1, 12);
      end
      repeat (n) begin
        pick_points(sx, sy, ex, ey);
        offer_pixel(sx, sy, ex, ey, 1'b0, NO_PIX);
      end
    end

    drain_all();
    repeat (SETTLE) @(posedge clk);
    $display("Checked %0d pixels (%0d from the table) over %0d register set-ups, %0d long stalls.",
             checked_count, directed_items, setups_done, holds_done);
    $display("Saw %0d frame ends, %0d coincident-point pixels and %0d saturated values.",
             frame_ends, flat_count, clipped_count);
    if (fault_count == 0 && pending_gradients.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/lgr_pkg.sv
hdl/linear_gradient_raster_unit.sv
tb/sv/testbench.sv
